FILE: sv/wcs_pkg.sv
package wcs_pkg;

  localparam int INPUT_BITS = 32;
  localparam int INDEX_BITS = 10;

  // Two weight banks: one set can load while the previous one is walked.
  localparam int MAX_SETS = 2;

  // Queue depth between the parts; a power of two so the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_WALK,
    ST_EMIT
  } wcs_state_t;

endpackage

FILE: sv/wcs_fifo.sv
module wcs_fifo
  import wcs_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] data_r [QUEUE_DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = data_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wp_r] <= wdata;
    end
  end

endmodule

FILE: sv/wcs_front.sv
module wcs_front
  import wcs_pkg::*;
#(
  parameter int MAX_CATEGORIES = 1024,
  parameter int WEIGHT_BITS    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [INPUT_BITS-1:0] in_weight,
  input  logic                  in_last,
  input  logic [INPUT_BITS-1:0] in_uniform,
  output logic                  wr_en,
  output logic [$clog2(MAX_CATEGORIES):0] wr_addr,
  output logic [((WEIGHT_BITS < INPUT_BITS) ? WEIGHT_BITS : INPUT_BITS)-1:0] wr_data,
  output logic                  job_push,
  output logic [((WEIGHT_BITS < INPUT_BITS) ? WEIGHT_BITS : INPUT_BITS)
                + $clog2(MAX_CATEGORIES) + $clog2(MAX_CATEGORIES + 1)
                + INPUT_BITS + 1:0] job_data,
  input  logic                  job_done
);

  localparam int SW = (WEIGHT_BITS < INPUT_BITS) ? WEIGHT_BITS : INPUT_BITS;
  localparam int IW = $clog2(MAX_CATEGORIES);
  localparam int CW = $clog2(MAX_CATEGORIES + 1);
  localparam int TW = SW + IW;
  localparam int SETW = $clog2(MAX_SETS + 1);

  logic [TW-1:0]   total_r, total_nxt, total_add;
  logic [CW-1:0]   cnt_r, cnt_nxt, cnt_add;
  logic            ovf_r, ovf_nxt, ovf_add;
  logic            bank_r, bank_nxt;
  logic [SETW-1:0] sets_r, sets_nxt;
  logic            accept, store;

  assign in_full = (sets_r == SETW'(MAX_SETS));
  assign accept  = in_push && !in_full;
  assign store   = (cnt_r < CW'(MAX_CATEGORIES));

  assign wr_en   = accept && store;
  assign wr_addr = {bank_r, cnt_r[IW-1:0]};
  assign wr_data = in_weight[SW-1:0];

  always_comb begin
    total_add = store ? total_r + TW'(in_weight[SW-1:0]) : total_r;
    cnt_add   = store ? cnt_r + 1'b1 : cnt_r;
    ovf_add   = ovf_r | !store;

    total_nxt = total_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    bank_nxt  = bank_r;
    job_push  = 1'b0;
    if (accept) begin
      if (in_last) begin
        // The finished set goes to the back part; the next set uses the other bank.
        job_push  = 1'b1;
        total_nxt = '0;
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
        bank_nxt  = !bank_r;
      end else begin
        total_nxt = total_add;
        cnt_nxt   = cnt_add;
        ovf_nxt   = ovf_add;
      end
    end

    sets_nxt = sets_r;
    if (job_push && !job_done) begin
      sets_nxt = sets_r + 1'b1;
    end else if (job_done && !job_push) begin
      sets_nxt = sets_r - 1'b1;
    end
  end

  assign job_data = {bank_r, total_add, cnt_add, in_uniform, ovf_add};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      bank_r  <= 1'b0;
      sets_r  <= '0;
    end else begin
      total_r <= total_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
      bank_r  <= bank_nxt;
      sets_r  <= sets_nxt;
    end
  end

endmodule

FILE: sv/wcs_back.sv
module wcs_back
  import wcs_pkg::*;
#(
  parameter int MAX_CATEGORIES = 1024,
  parameter int WEIGHT_BITS    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [$clog2(MAX_CATEGORIES):0] wr_addr,
  input  logic [((WEIGHT_BITS < INPUT_BITS) ? WEIGHT_BITS : INPUT_BITS)-1:0] wr_data,
  input  logic                  job_empty,
  input  logic [((WEIGHT_BITS < INPUT_BITS) ? WEIGHT_BITS : INPUT_BITS)
                + $clog2(MAX_CATEGORIES) + $clog2(MAX_CATEGORIES + 1)
                + INPUT_BITS + 1:0] job_data,
  output logic                  job_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output logic [INDEX_BITS:0]   res_data
);

  localparam int SW = (WEIGHT_BITS < INPUT_BITS) ? WEIGHT_BITS : INPUT_BITS;
  localparam int IW = $clog2(MAX_CATEGORIES);
  localparam int CW = $clog2(MAX_CATEGORIES + 1);
  localparam int TW = SW + IW;
  localparam int AW = IW + 1;
  localparam int PROD_BITS = 2 * INPUT_BITS;

  logic [SW-1:0] mem [2**AW];

  wcs_state_t state_r, state_nxt;

  logic                  bank_r, bank_nxt;
  logic [TW-1:0]         total_r, total_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [INPUT_BITS-1:0] u_r, u_nxt;
  logic                  ovf_r, ovf_nxt;

  logic [PROD_BITS-1:0]  p_lo_r, p_lo_nxt;
  logic [PROD_BITS-1:0]  p_hi_r, p_hi_nxt;
  logic [PROD_BITS-1:0]  tot_wide;
  logic [TW-1:0]         mass_r, mass_nxt;
  logic [TW-1:0]         acc_r, acc_nxt, acc_sum;
  logic [CW-1:0]         addr_r, addr_nxt;
  logic [IW-1:0]         rdq_idx_r, rdq_idx_nxt;
  logic                  rd_valid_r, rd_valid_nxt;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [SW-1:0]         rdata_r;
  logic [IW-1:0]         chosen_r, chosen_nxt;

  logic                  j_bank;
  logic [TW-1:0]         j_total;
  logic [CW-1:0]         j_cnt;
  logic [INPUT_BITS-1:0] j_u;
  logic                  j_ovf;

  assign {j_bank, j_total, j_cnt, j_u, j_ovf} = job_data;
  assign tot_wide = PROD_BITS'(total_r);
  assign acc_sum  = acc_r + TW'(rdata_r);
  assign rd_addr  = {bank_r, addr_r[IW-1:0]};
  assign res_data = {INDEX_BITS'(chosen_r), ovf_r};

  always_comb begin
    state_nxt    = state_r;
    bank_nxt     = bank_r;
    total_nxt    = total_r;
    cnt_nxt      = cnt_r;
    u_nxt        = u_r;
    ovf_nxt      = ovf_r;
    p_lo_nxt     = p_lo_r;
    p_hi_nxt     = p_hi_r;
    mass_nxt     = mass_r;
    acc_nxt      = acc_r;
    addr_nxt     = addr_r;
    rdq_idx_nxt  = rdq_idx_r;
    rd_valid_nxt = 1'b0;
    rd_en        = 1'b0;
    chosen_nxt   = chosen_r;
    job_pop      = 1'b0;
    res_push     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop   = 1'b1;
          bank_nxt  = j_bank;
          total_nxt = j_total;
          cnt_nxt   = j_cnt;
          u_nxt     = j_u;
          ovf_nxt   = j_ovf;
          state_nxt = ST_MUL_LO;
        end
      end
      ST_MUL_LO: begin
        p_lo_nxt  = PROD_BITS'(u_r) * PROD_BITS'(tot_wide[INPUT_BITS-1:0]);
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        p_hi_nxt  = PROD_BITS'(u_r) * PROD_BITS'(tot_wide[PROD_BITS-1:INPUT_BITS]);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // floor(u * total / 2^32); the result never exceeds the total.
        mass_nxt = TW'(p_hi_r + (p_lo_r >> INPUT_BITS));
        acc_nxt  = '0;
        addr_nxt = '0;
        if (total_r == '0 || cnt_r == '0) begin
          chosen_nxt = '0;
          state_nxt  = ST_EMIT;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // Reads are issued one per cycle; each returns in the next cycle and is
        // added to the running mass while the next read is under way.
        if (addr_r < cnt_r) begin
          rd_en        = 1'b1;
          rd_valid_nxt = 1'b1;
          rdq_idx_nxt  = addr_r[IW-1:0];
          addr_nxt     = addr_r + 1'b1;
        end
        if (rd_valid_r) begin
          acc_nxt = acc_sum;
          if (acc_sum >= mass_r) begin
            chosen_nxt   = rdq_idx_r;
            rd_valid_nxt = 1'b0;
            state_nxt    = ST_EMIT;
          end
        end else if (addr_r == cnt_r) begin
          chosen_nxt = IW'(cnt_r - 1'b1);
          state_nxt  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= rd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r    <= bank_nxt;
    total_r   <= total_nxt;
    cnt_r     <= cnt_nxt;
    u_r       <= u_nxt;
    ovf_r     <= ovf_nxt;
    p_lo_r    <= p_lo_nxt;
    p_hi_r    <= p_hi_nxt;
    mass_r    <= mass_nxt;
    acc_r     <= acc_nxt;
    addr_r    <= addr_nxt;
    rdq_idx_r <= rdq_idx_nxt;
    chosen_r  <= chosen_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/weighted_category_sampler_unit.sv
// Roulette-wheel sampler: picks one category from a set of weights.
// Input channel (in_push / in_full): one weight per item, one item per cycle
// while in_full is low. The item with in_last high closes the set and carries
// the random fraction in_uniform. Weights beyond MAX_CATEGORIES are dropped
// and reported through out_overflowed.
// Result channel (out_empty / out_pop): one result per set, in set order.
// Weights are kept in two banks, so a new set loads while the previous one is
// being walked; in_full rises only when both banks hold sets not yet walked.
// From the last item of a set to its result: a queue hop, two 32x32
// multiply steps and a sum for the target mass, then a walk that reads one
// stored weight per cycle from the single memory read port, up to the
// chosen index. The walker finishes one set before it takes the next.
// When out_pop stays low, two results wait in the output queue, the walker
// holds the next one, and then input stalls once both banks are taken.
// Reset (rst_n low, synchronous) empties both queues and the current set;
// the weight memory itself is not cleared and needs no clearing pass.
module weighted_category_sampler_unit
  import wcs_pkg::*;
#(
  parameter int MAX_CATEGORIES = 1024,
  parameter int WEIGHT_BITS    = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [INPUT_BITS-1:0] in_weight,
  input  logic                  in_last,
  input  logic [INPUT_BITS-1:0] in_uniform,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [INDEX_BITS-1:0] out_chosen_index,
  output logic                  out_overflowed
);

  localparam int SW = (WEIGHT_BITS < INPUT_BITS) ? WEIGHT_BITS : INPUT_BITS;
  localparam int IW = $clog2(MAX_CATEGORIES);
  localparam int CW = $clog2(MAX_CATEGORIES + 1);
  localparam int TW = SW + IW;
  localparam int JW = 1 + TW + CW + INPUT_BITS + 1;
  localparam int RW = INDEX_BITS + 1;

  logic          wr_en;
  logic [IW:0]   wr_addr;
  logic [SW-1:0] wr_data;
  logic          job_push, job_pop, job_full, job_empty;
  logic [JW-1:0] job_wdata, job_rdata;
  logic          res_push, res_full;
  logic [RW-1:0] res_wdata, res_rdata;

  wcs_front #(
    .MAX_CATEGORIES(MAX_CATEGORIES),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_weight (in_weight),
    .in_last   (in_last),
    .in_uniform(in_uniform),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .job_push  (job_push),
    .job_data  (job_wdata),
    .job_done  (res_push)
  );

  wcs_fifo #(
    .WIDTH(JW)
  ) u_job_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (job_push),
    .wdata(job_wdata),
    .full (job_full),
    .pop  (job_pop),
    .rdata(job_rdata),
    .empty(job_empty)
  );

  wcs_back #(
    .MAX_CATEGORIES(MAX_CATEGORIES),
    .WEIGHT_BITS   (WEIGHT_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .job_empty(job_empty),
    .job_data (job_rdata),
    .job_pop  (job_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_wdata)
  );

  wcs_fifo #(
    .WIDTH(RW)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res_wdata),
    .full (res_full),
    .pop  (out_pop),
    .rdata(res_rdata),
    .empty(out_empty)
  );

  // The job queue holds at most one entry per weight bank, so it never fills
  // while the front part is still accepting items.
  logic job_full_unused;
  assign job_full_unused = job_full;

  assign out_chosen_index = res_rdata[RW-1:1];
  assign out_overflowed   = res_rdata[0];

endmodule
